@@ design/mjcs_pkg.sv @@
// Shared types and constants for the modem join command sequencer.
package mjcs_pkg;

    // Join machine states
    localparam logic [3:0] PH_STARTUP   = 4'd0;
    localparam logic [3:0] PH_RESET     = 4'd1;
    localparam logic [3:0] PH_SETINFO   = 4'd2;
    localparam logic [3:0] PH_METHOD    = 4'd3;
    localparam logic [3:0] PH_CHK_ABP   = 4'd4;
    localparam logic [3:0] PH_WAIT_ABP  = 4'd5;
    localparam logic [3:0] PH_CHK_OTAA  = 4'd6;
    localparam logic [3:0] PH_WAIT_OTAA = 4'd7;
    localparam logic [3:0] PH_JOINED    = 4'd8;
    localparam logic [3:0] PH_NEEDKEYS  = 4'd9;
    localparam logic [3:0] PH_FAILURE   = 4'd10;

    // Command codes
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_RESET     = 4'd1;
    localparam logic [3:0] CMD_DEV_ADDR  = 4'd2;
    localparam logic [3:0] CMD_NWK_KEY   = 4'd3;
    localparam logic [3:0] CMD_APP_SKEY  = 4'd4;
    localparam logic [3:0] CMD_APP_EUI   = 4'd5;
    localparam logic [3:0] CMD_APP_KEY   = 4'd6;
    localparam logic [3:0] CMD_JOIN_ABP  = 4'd7;
    localparam logic [3:0] CMD_JOIN_OTAA = 4'd8;

    localparam logic JOIN_MODE_ABP = 1'b0;

    // Join attempts allowed before giving up
    localparam int unsigned RETRY_LIMIT = 5;

    // Received bytes of interest
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_R   = 8'h52;
    localparam logic [7:0] CH_N   = 8'h4E;

    // Longest keyword plus its terminator: nothing past this decides a match
    localparam int KW_SPAN  = 14;
    localparam int KW_IDX_W = $clog2(KW_SPAN);
    localparam int KW_BITS  = 8 * KW_SPAN;

    typedef logic [KW_SPAN-1:0][7:0] line_t;
    typedef logic [KW_BITS-1:0] kw_t;   // first character in the top byte

    localparam kw_t KW_OK        = {"ok", {(KW_SPAN-2){8'h00}}};
    localparam kw_t KW_NO_KEYS   = {"keys_", "not", "_init", {(KW_SPAN-13){8'h00}}};
    localparam kw_t KW_BAD_PARAM = {"invalid", "_param", {(KW_SPAN-13){8'h00}}};
    localparam kw_t KW_NO_CHAN   = {"no_free", "_ch", {(KW_SPAN-10){8'h00}}};
    localparam kw_t KW_ACCEPTED  = {"accepted", {(KW_SPAN-8){8'h00}}};
    localparam kw_t KW_DENIED    = {"denied", {(KW_SPAN-6){8'h00}}};

    localparam logic [KW_IDX_W-1:0] LEN_OK        = KW_IDX_W'(2);
    localparam logic [KW_IDX_W-1:0] LEN_NO_KEYS   = KW_IDX_W'(13);
    localparam logic [KW_IDX_W-1:0] LEN_BAD_PARAM = KW_IDX_W'(13);
    localparam logic [KW_IDX_W-1:0] LEN_NO_CHAN   = KW_IDX_W'(10);
    localparam logic [KW_IDX_W-1:0] LEN_ACCEPTED  = KW_IDX_W'(8);
    localparam logic [KW_IDX_W-1:0] LEN_DENIED    = KW_IDX_W'(6);

    // One item's worth of results, drained one command per cycle while m_ready is high
    typedef struct packed {
        logic [2:0][3:0] cmd;
        logic [1:0]      cnt;
        logic [3:0]      phase;
        logic            running;
    } pkt_t;

    // Line equals keyword: all its characters, then a terminator
    function automatic logic line_is(input line_t line, input kw_t kw,
                                     input logic [KW_IDX_W-1:0] len);
        logic hit;
        hit = 1'b1;
        for (int i = 0; i < KW_SPAN; i++) begin
            if (i < int'(len)) begin
                if (line[i] != kw[KW_BITS-1-8*i -: 8]) hit = 1'b0;
            end else if (i == int'(len)) begin
                if (line[i] != CH_NUL) hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

@@ design/modem_join_command_sequencer.sv @@
// Join command sequencer: line capture, keyword match and join state machine.

// A request is taken in any cycle the skid slot is free, so a new one may follow
// every cycle. A received byte yields one result; a poll yields one to three
// results (one per emitted command, or a single none); the result port shows
// one per cycle while m_ready is high, so a poll issuing several commands holds
// the output until each is taken; sustained throughput is set by that port.
// Only the first 14 line bytes are kept in flops, as no keyword reaches further;
// the write index counts on, saturating at LINE_DEPTH. No clearing after reset.
module modem_join_command_sequencer
    import mjcs_pkg::*;
#(
    parameter int LINE_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_command,
    output logic       m_last,
    output logic [3:0] m_join_state,
    output logic       m_running
);

    localparam int IDX_W = $clog2(LINE_DEPTH + 1);

    logic                join_mode_reg;
    line_t               line_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                line_ready_reg, line_ready_next;
    logic [3:0]          phase_reg, phase_next;
    logic                running_reg, running_next;
    logic [3:0]          attempt_reg, attempt_next;

    logic                lw_en;
    logic [KW_IDX_W-1:0] lw_addr;
    logic [7:0]          lw_data;

    pkt_t                head_reg, head_next, pend_reg, pend_next, new_pkt;
    logic                head_valid_reg, head_valid_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [1:0]          pos_reg, pos_next;

    logic                acc, head_done, rdy;
    logic [1:0]          n_cmd;
    logic [2:0][3:0]     cmd_v;
    logic [4:0]          attempt_sum;
    logic                hit_rn, hit_ok, hit_keys, hit_inval, hit_nofree, hit_acc, hit_deny;

    assign hit_rn     = (line_reg[0] == CH_R) && (line_reg[1] == CH_N);
    assign hit_ok     = line_is(line_reg, KW_OK, LEN_OK);
    assign hit_keys   = line_is(line_reg, KW_NO_KEYS, LEN_NO_KEYS);
    assign hit_inval  = line_is(line_reg, KW_BAD_PARAM, LEN_BAD_PARAM);
    assign hit_nofree = line_is(line_reg, KW_NO_CHAN, LEN_NO_CHAN);
    assign hit_acc    = line_is(line_reg, KW_ACCEPTED, LEN_ACCEPTED);
    assign hit_deny   = line_is(line_reg, KW_DENIED, LEN_DENIED);

    assign s_ready      = !pend_valid_reg;
    assign acc          = s_valid && s_ready;
    assign m_valid      = head_valid_reg;
    assign m_command    = head_reg.cmd[pos_reg];
    assign m_last       = (pos_reg == head_reg.cnt - 2'd1);
    assign m_join_state = head_reg.phase;
    assign m_running    = head_reg.running;
    assign head_done    = head_valid_reg && m_ready && m_last;
    assign attempt_sum  = {1'b0, attempt_reg} + 5'd1;

    // Line capture and join machine, evaluated on the accepted request
    always_comb begin
        idx_next        = idx_reg;
        line_ready_next = line_ready_reg;
        phase_next      = phase_reg;
        running_next    = running_reg;
        attempt_next    = attempt_reg;
        lw_en           = 1'b0;
        lw_addr         = idx_reg[KW_IDX_W-1:0];
        lw_data         = s_rx_byte;
        cmd_v           = '{CMD_NONE, CMD_NONE, CMD_NONE};
        n_cmd           = 2'd0;
        rdy             = line_ready_reg;
        if (acc) begin
            if (s_action) begin
                if (s_rx_byte == CH_CR) begin
                    lw_en           = (idx_reg < IDX_W'(KW_SPAN));
                    lw_data         = CH_NUL;
                    idx_next        = '0;
                    line_ready_next = 1'b1;
                end else if (s_rx_byte != CH_NUL && s_rx_byte != CH_LF) begin
                    if (idx_reg < IDX_W'(LINE_DEPTH)) begin
                        lw_en    = (idx_reg < IDX_W'(KW_SPAN));
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end else begin
                line_ready_next = 1'b0;
                if (!running_reg) begin
                    case (phase_reg)
                        PH_STARTUP: begin
                            cmd_v[0]   = CMD_RESET;
                            n_cmd      = 2'd1;
                            phase_next = PH_RESET;
                        end
                        PH_RESET: begin
                            if (rdy) phase_next = hit_rn ? PH_SETINFO : PH_FAILURE;
                        end
                        PH_SETINFO: begin
                            if (join_mode_reg == JOIN_MODE_ABP) begin
                                cmd_v = '{CMD_APP_SKEY, CMD_NWK_KEY, CMD_DEV_ADDR};
                                n_cmd = 2'd3;
                            end else begin
                                cmd_v = '{CMD_NONE, CMD_APP_KEY, CMD_APP_EUI};
                                n_cmd = 2'd2;
                            end
                            phase_next = PH_METHOD;
                        end
                        PH_METHOD: begin
                            if (rdy) begin
                                n_cmd = 2'd1;
                                if (join_mode_reg == JOIN_MODE_ABP) begin
                                    cmd_v[0]   = CMD_JOIN_ABP;
                                    phase_next = PH_CHK_ABP;
                                end else begin
                                    cmd_v[0]   = CMD_JOIN_OTAA;
                                    phase_next = PH_CHK_OTAA;
                                end
                                attempt_next = (attempt_sum > 5'd15) ? 4'd15 : attempt_sum[3:0];
                                // limit checked on the unsaturated count
                                if (attempt_sum > 5'(RETRY_LIMIT)) phase_next = PH_FAILURE;
                            end
                        end
                        PH_CHK_ABP: begin
                            if (rdy) begin
                                if (hit_ok) begin
                                    phase_next = PH_WAIT_ABP;
                                end else if (hit_keys) begin
                                    phase_next = PH_NEEDKEYS;
                                end else begin
                                    cmd_v[0] = CMD_JOIN_ABP;
                                    n_cmd    = 2'd1;
                                end
                            end
                        end
                        PH_WAIT_ABP: begin
                            if (rdy) phase_next = hit_acc ? PH_JOINED : PH_STARTUP;
                        end
                        PH_CHK_OTAA: begin
                            if (rdy) begin
                                if (hit_ok)          phase_next = PH_WAIT_OTAA;
                                else if (hit_keys)   phase_next = PH_NEEDKEYS;
                                else if (hit_inval)  phase_next = PH_METHOD;
                                else if (hit_nofree) phase_next = PH_STARTUP;
                            end
                        end
                        PH_WAIT_OTAA: begin
                            if (rdy) begin
                                if (hit_acc)         phase_next = PH_JOINED;
                                else if (hit_deny)   phase_next = PH_METHOD;
                                else if (hit_nofree) phase_next = PH_STARTUP;
                            end
                        end
                        PH_JOINED: begin
                            attempt_next = 4'd0;
                            running_next = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
        new_pkt.cmd     = cmd_v;
        new_pkt.cnt     = (n_cmd == 2'd0) ? 2'd1 : n_cmd;
        new_pkt.phase   = phase_next;
        new_pkt.running = running_next;
    end

    // Result head plus one skid slot
    always_comb begin
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        pos_next        = pos_reg;
        if (!head_valid_reg || head_done) begin
            pos_next = 2'd0;
            if (pend_valid_reg) begin
                head_next       = pend_reg;
                head_valid_next = 1'b1;
                pend_valid_next = 1'b0;
            end else begin
                head_next       = new_pkt;
                head_valid_next = acc;
            end
        end else begin
            if (m_ready) pos_next = pos_reg + 2'd1;
            if (acc) begin
                pend_next       = new_pkt;
                pend_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            join_mode_reg  <= JOIN_MODE_ABP;
            idx_reg        <= '0;
            line_ready_reg <= 1'b0;
            phase_reg      <= PH_STARTUP;
            running_reg    <= 1'b0;
            attempt_reg    <= 4'd0;
            head_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            pos_reg        <= 2'd0;
        end else begin
            if (cfg_wr_en) join_mode_reg <= cfg_wr_data;
            idx_reg        <= idx_next;
            line_ready_reg <= line_ready_next;
            phase_reg      <= phase_next;
            running_reg    <= running_next;
            attempt_reg    <= attempt_next;
            head_valid_reg <= head_valid_next;
            pend_valid_reg <= pend_valid_next;
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (lw_en) line_reg[lw_addr] <= lw_data;
        head_reg <= head_next;
        pend_reg <= pend_next;
    end

    a_pend_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> head_valid_reg)
        else $error("skid slot filled with empty head");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid_reg |-> (pos_reg < head_reg.cnt))
        else $error("result position past command count");

    a_running_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |=> running_reg)
        else $error("running flag dropped");

    a_running_joined: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (phase_reg == PH_JOINED))
        else $error("running outside joined state");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_W'(LINE_DEPTH))
        else $error("line index beyond depth");

endmodule
